### rtl/dkes_pkg.sv
// Shared types and constants for the delayed key event scheduler.
`default_nettype none
package dkes_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int BUTTONS     = 32;
	localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int BTN_W       = 5;
	localparam int BIDX_W      = $clog2(BUTTONS);
	localparam int RATE_W      = 18;
	localparam int MS_W        = 16;
	localparam int FRAME_W     = 64;
	localparam int PROD_W      = MS_W + RATE_W;
	localparam int MS_PER_S    = 1000;
	// divide by 1000: drop three bits (1000 = 8 * 125), then multiply by 2^35 / 125
	localparam int PRE_SH      = 3;
	localparam int DIVQ_W      = PROD_W - PRE_SH;
	localparam int RECIP_W     = 29;
	localparam int RPROD_W     = DIVQ_W + RECIP_W;
	localparam int RECIP_SH    = 35;
	localparam logic [RECIP_W-1:0] RECIP_125 = RECIP_W'(274877907);
	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(32000);

	typedef enum logic [2:0] {
		ACT_KEY     = 3'd0,
		ACT_DELAY   = 3'd1,
		ACT_ADVANCE = 3'd2,
		ACT_PWR_ON  = 3'd3,
		ACT_PWR_OFF = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_ENQ,
		ST_ADV,
		ST_PWR,
		ST_FLUSH
	} state_t;

	// One queued key: due frame, press or release, button.
	typedef struct packed {
		logic [FRAME_W-1:0] due;
		logic               down;
		logic [BTN_W-1:0]   btn;
	} pend_t;

endpackage
`default_nettype wire

### rtl/delayed_key_event_scheduler_unit.sv
// Top level: key event scheduler with a queue of delayed keys in a synchronous memory.
// Direct key: its result, when powered, goes from the flush state into a free output register.
// Delayed key: busy through the multiply, reciprocal divide by 1000 and queue write states
// after accept, no result; dropped when the queue is full.
// Advance: one queued entry per cycle (memory read pipelined with the compare) unless a full output register stalls.
// Power on: one button per cycle over all BUTTONS, stalled by a full output register.
// Reset is asynchronous: clears control, counter, held marks, power flag and fill count, and loads the default rate.
`default_nettype none
module delayed_key_event_scheduler_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [2:0]                 action,
	input  wire logic [dkes_pkg::BTN_W-1:0] button,
	input  wire logic                       down,
	input  wire logic [dkes_pkg::MS_W-1:0]  delay_ms,
	input  wire logic [dkes_pkg::MS_W-1:0]  advance_frames,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [dkes_pkg::BTN_W-1:0]      key_index,
	output logic                            key_pressed,
	output logic                            last_in_run,
	input  wire logic                       cfg_we,
	input  wire logic [dkes_pkg::RATE_W-1:0] cfg_wdata
);
	import dkes_pkg::*;

	state_t state_q, state_d;

	logic [RATE_W-1:0]  rate_q;
	logic [FRAME_W-1:0] fc_q;
	logic               powered_q;
	logic [BUTTONS-1:0] held_q;
	logic [QCNT_W-1:0]  count_q;
	logic [QIDX_W-1:0]  idx_q;
	logic [QCNT_W-1:0]  kept_q;
	logic [BIDX_W-1:0]  bidx_q;

	// delayed key work registers
	logic [MS_W-1:0]    ms_q;
	logic [PROD_W-1:0]  div_q;
	logic [BTN_W-1:0]   dbtn_q;
	logic               ddown_q;

	// result waiting for its successor, so the last one can be marked
	logic               cand_valid_q;
	logic [BTN_W-1:0]   cand_key_q;
	logic               cand_down_q;

	logic               out_valid_q;
	logic [BTN_W-1:0]   out_key_q;
	logic               out_down_q;
	logic               out_last_q;

	pend_t              mem [QUEUE_DEPTH];
	pend_t              rd_q;

	logic               accept;
	logic               out_free;
	logic               fire;
	logic               new_emit;
	logic [BTN_W-1:0]   new_key;
	logic               new_down;
	logic               step;
	logic               push;
	logic               adv_last;
	logic [QCNT_W-1:0]  kept_next;
	logic               mem_we;
	logic [QIDX_W-1:0]  mem_wa;
	pend_t              mem_wd;
	logic               mem_re;
	logic [QIDX_W-1:0]  mem_ra;
	logic [RPROD_W-1:0] recip_prod;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign recip_prod = RPROD_W'(div_q[PROD_W-1:PRE_SH]) * RPROD_W'(RECIP_125);
	assign fire     = rd_q.due <= fc_q;
	assign adv_last = {1'b0, idx_q} == (count_q - QCNT_W'(1));
	assign kept_next = kept_q + QCNT_W'(!fire);

	assign out_valid   = out_valid_q;
	assign key_index   = out_key_q;
	assign key_pressed = out_down_q;
	assign last_in_run = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		new_emit = 1'b0;
		new_key  = rd_q.btn;
		new_down = rd_q.down;
		step     = 1'b0;
		push     = 1'b0;
		mem_we   = 1'b0;
		mem_wa   = kept_q[QIDX_W-1:0];
		mem_wd   = rd_q;
		mem_re   = 1'b0;
		mem_ra   = idx_q + QIDX_W'(1);
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				mem_ra   = '0;
				if (in_valid) begin
					case (action)
						ACT_KEY: state_d = ST_FLUSH;
						ACT_DELAY: begin
							if (count_q < QCNT_W'(QUEUE_DEPTH)) state_d = ST_MUL;
						end
						ACT_ADVANCE: begin
							mem_re  = 1'b1;
							state_d = (count_q == '0) ? ST_FLUSH : ST_ADV;
						end
						ACT_PWR_ON: begin
							if (!powered_q) state_d = ST_PWR;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_MUL: state_d = ST_DIV;
			ST_DIV: state_d = ST_ENQ;
			ST_ENQ: begin
				mem_we  = 1'b1;
				mem_wa  = count_q[QIDX_W-1:0];
				mem_wd  = '{due: fc_q + FRAME_W'(div_q), down: ddown_q, btn: dbtn_q};
				state_d = ST_IDLE;
			end
			ST_ADV: begin
				new_emit = fire && powered_q;
				step     = !(new_emit && cand_valid_q && !out_free);
				push     = step && new_emit && cand_valid_q;
				mem_we   = step && !fire;
				if (step) begin
					if (adv_last) begin
						state_d = ST_FLUSH;
					end else begin
						mem_re = 1'b1;
					end
				end
			end
			ST_PWR: begin
				new_emit = held_q[bidx_q];
				new_key  = BTN_W'(bidx_q);
				new_down = 1'b1;
				step     = !(new_emit && cand_valid_q && !out_free);
				push     = step && new_emit && cand_valid_q;
				if (step && bidx_q == BIDX_W'(BUTTONS - 1)) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				push = cand_valid_q && out_free;
				if (!cand_valid_q || out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// queue memory: one write port, one registered read port, no reset
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (mem_re) rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q       <= RATE_RESET;
			fc_q         <= '0;
			powered_q    <= 1'b0;
			held_q       <= '0;
			count_q      <= '0;
			idx_q        <= '0;
			kept_q       <= '0;
			bidx_q       <= '0;
			cand_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) rate_q <= cfg_wdata;
			if (push) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;

			if (accept) begin
				case (action)
					ACT_KEY: begin
						held_q[button] <= down;
						if (powered_q) cand_valid_q <= 1'b1;
					end
					ACT_ADVANCE: begin
						fc_q   <= fc_q + FRAME_W'(advance_frames);
						idx_q  <= '0;
						kept_q <= '0;
					end
					ACT_PWR_ON: begin
						powered_q <= 1'b1;
						bidx_q    <= '0;
					end
					ACT_PWR_OFF: powered_q <= 1'b0;
					default: ;
				endcase
			end

			if (state_q == ST_ENQ) count_q <= count_q + QCNT_W'(1);

			if (state_q == ST_ADV && step) begin
				kept_q <= kept_next;
				idx_q  <= idx_q + QIDX_W'(1);
				if (fire) held_q[rd_q.btn] <= rd_q.down;
				if (adv_last) count_q <= kept_next;
			end
			if (state_q == ST_PWR && step) bidx_q <= bidx_q + BIDX_W'(1);

			if ((state_q == ST_ADV || state_q == ST_PWR) && step && new_emit) begin
				cand_valid_q <= 1'b1;
			end
			if (state_q == ST_FLUSH && push) cand_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept && action == ACT_KEY) begin
			cand_key_q  <= button;
			cand_down_q <= down;
		end
		if (accept && action == ACT_DELAY) begin
			ms_q    <= (delay_ms == '0) ? MS_W'(1) : delay_ms;
			dbtn_q  <= button;
			ddown_q <= down;
		end
		if (state_q == ST_MUL) begin
			div_q <= PROD_W'(ms_q * rate_q);
		end
		// divide by 1000 through the reciprocal of 125
		if (state_q == ST_DIV) begin
			div_q <= PROD_W'(recip_prod[RPROD_W-1:RECIP_SH]);
		end
		if ((state_q == ST_ADV || state_q == ST_PWR) && step && new_emit) begin
			cand_key_q  <= new_key;
			cand_down_q <= new_down;
		end
		if (push) begin
			out_key_q  <= cand_key_q;
			out_down_q <= cand_down_q;
			out_last_q <= (state_q == ST_FLUSH);
		end
	end

endmodule
`default_nettype wire

### rtl/dkes_checker.sv
// Port-level checks for the key event scheduler, bound to the top level.
`default_nettype none
module dkes_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic [2:0]                  action,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [dkes_pkg::BTN_W-1:0]  key_index,
	input wire logic                        key_pressed,
	input wire logic                        last_in_run
);
	import dkes_pkg::*;

	// a result that is not the last of its run means the block is still busy
	a_busy_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_in_run |-> !in_ready)
		else $error("ready while a run is incomplete");

	// power off is done in the cycle it is taken
	a_pwr_off_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && action == ACT_PWR_OFF |=> in_ready)
		else $error("power off left the block busy");

	// unknown actions produce nothing and keep the block ready
	a_unknown_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (action == 3'd5 || action == 3'd6 || action == 3'd7)
		|=> in_ready)
		else $error("unknown action left the block busy");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(key_index)
		&& $stable(key_pressed) && $stable(last_in_run))
		else $error("stalled result changed");

endmodule

bind delayed_key_event_scheduler_unit dkes_checker u_dkes_checker (.*);
`default_nettype wire

### sim/delayed_key_event_scheduler_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the delayed key event scheduler: key stream predicted per item.
module delayed_key_event_scheduler_unit_tb;
	import dkes_pkg::*;

	localparam int SETTLE_CYCLES = 80;
	localparam int QUIET_LIMIT   = 2000;
	localparam int PRINT_LIMIT   = 200;
	localparam int MAX_RUN       = 32;
	localparam logic [2:0] ACT_CODE_MAX = '1;

	typedef struct packed {
		logic [BTN_W-1:0] idx;
		logic             pressed;
		logic             last;
	} key_event_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [2:0]          action = '0;
	logic [BTN_W-1:0]    button = '0;
	logic                down = 1'b0;
	logic [MS_W-1:0]     delay_ms = '0;
	logic [MS_W-1:0]     advance_frames = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [BTN_W-1:0]    key_index;
	logic                key_pressed;
	logic                last_in_run;
	logic                cfg_we = 1'b0;
	logic [RATE_W-1:0]   cfg_wdata = '0;

	// scheduler state as predicted
	logic [RATE_W-1:0]   rate_model;
	logic [FRAME_W-1:0]  frames_model;
	logic                powered_model;
	logic [BUTTONS-1:0]  held_model;
	logic [FRAME_W-1:0]  pend_due [QUEUE_DEPTH];
	logic [BTN_W-1:0]    pend_btn [QUEUE_DEPTH];
	logic                pend_down [QUEUE_DEPTH];
	int                  pend_count;
	int                  run_len;
	key_event_t          expected_keys[$];
	key_event_t          head_key;

	int                  errors = 0;
	int                  quiet_cycles = 0;
	int                  gap_pct = 0;
	int                  stall_pct = 0;
	int                  sink_hold = 0;

	delayed_key_event_scheduler_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.button(button),
		.down(down),
		.delay_ms(delay_ms),
		.advance_frames(advance_frames),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.key_index(key_index),
		.key_pressed(key_pressed),
		.last_in_run(last_in_run),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		errors++;
		if (errors <= PRINT_LIMIT)
			$display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
	endtask

	task automatic forward_key(input logic [BTN_W-1:0] btn, input logic dn);
		key_event_t ev;
		// one item returns at most MAX_RUN keys
		if (run_len < MAX_RUN) begin
			ev.idx = btn;
			ev.pressed = dn;
			ev.last = 1'b0;
			expected_keys.push_back(ev);
			run_len++;
		end
	endtask

	task automatic apply_key(input logic [BTN_W-1:0] btn, input logic dn);
		held_model[btn] = dn;
		if (powered_model)
			forward_key(btn, dn);
	endtask

	task automatic predict_item(input logic [2:0] act, input logic [BTN_W-1:0] btn,
		input logic dn, input logic [MS_W-1:0] ms, input logic [MS_W-1:0] frames);
		logic [FRAME_W-1:0] span;
		key_event_t tail;
		int kept;
		run_len = 0;
		case (act)
		ACT_KEY: begin
			apply_key(btn, dn);
		end
		ACT_DELAY: begin
			// drop the key silently when the queue is full
			if (pend_count < QUEUE_DEPTH) begin
				span = (ms == '0) ? FRAME_W'(1) : FRAME_W'(ms);
				span = span * FRAME_W'(rate_model) / MS_PER_S;
				pend_due[pend_count] = frames_model + span;
				pend_btn[pend_count] = btn;
				pend_down[pend_count] = dn;
				pend_count++;
			end
		end
		ACT_ADVANCE: begin
			frames_model = frames_model + FRAME_W'(frames);
			kept = 0;
			for (int i = 0; i < pend_count; i++) begin
				if (pend_due[i] <= frames_model) begin
					apply_key(pend_btn[i], pend_down[i]);
				end else begin
					pend_due[kept] = pend_due[i];
					pend_btn[kept] = pend_btn[i];
					pend_down[kept] = pend_down[i];
					kept++;
				end
			end
			pend_count = kept;
		end
		ACT_PWR_ON: begin
			if (!powered_model) begin
				powered_model = 1'b1;
				for (int b = 0; b < BUTTONS; b++)
					if (held_model[b])
						forward_key(BTN_W'(b), 1'b1);
			end
		end
		ACT_PWR_OFF: begin
			powered_model = 1'b0;
		end
		default: begin
		end
		endcase
		if (run_len > 0) begin
			tail = expected_keys.pop_back();
			tail.last = 1'b1;
			expected_keys.push_back(tail);
		end
	endtask

	task automatic hold_input(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic send_item(input logic [2:0] act, input logic [BTN_W-1:0] btn,
		input logic dn, input logic [MS_W-1:0] ms, input logic [MS_W-1:0] frames);
		if (gap_pct > 0 && $urandom_range(99, 0) < gap_pct)
			hold_input($urandom_range(5, 1));
		in_valid <= 1'b1;
		action <= act;
		button <= btn;
		down <= dn;
		delay_ms <= ms;
		advance_frames <= frames;
		do @(posedge clk); while (!in_ready);
		predict_item(act, btn, dn, ms, frames);
	endtask

	// wait out every pending key, then the longest silent item
	task automatic drain_block();
		in_valid <= 1'b0;
		while (expected_keys.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_rate(input logic [RATE_W-1:0] rate);
		cfg_we <= 1'b1;
		cfg_wdata <= rate;
		@(posedge clk);
		cfg_we <= 1'b0;
		rate_model = rate;
	endtask

	task automatic send_random_item();
		int pick;
		logic [MS_W-1:0] ms;
		logic [MS_W-1:0] frames;
		pick = $urandom_range(99, 0);
		ms = ($urandom_range(99, 0) < 85) ? MS_W'($urandom_range(30, 0)) :
			MS_W'($urandom_range(2000, 0));
		frames = ($urandom_range(99, 0) < 70) ? MS_W'($urandom_range(500, 0)) :
			MS_W'($urandom);
		if (pick < 30)
			send_item(ACT_KEY, BTN_W'($urandom), 1'($urandom), MS_W'($urandom), frames);
		else if (pick < 60)
			send_item(ACT_DELAY, BTN_W'($urandom), 1'($urandom), ms, MS_W'($urandom));
		else if (pick < 85)
			send_item(ACT_ADVANCE, BTN_W'($urandom), 1'($urandom), ms, frames);
		else if (pick < 92)
			send_item(ACT_PWR_ON, BTN_W'($urandom), 1'($urandom), ms, frames);
		else if (pick < 97)
			send_item(ACT_PWR_OFF, BTN_W'($urandom), 1'($urandom), ms, frames);
		else
			send_item(3'($urandom_range(int'(ACT_CODE_MAX), int'(ACT_PWR_OFF) + 1)),
				BTN_W'($urandom), 1'($urandom), ms, frames);
	endtask

	task automatic test_unpowered_keys();
		send_item(ACT_KEY, '0, 1'b1, '1, '0);
		send_item(ACT_KEY, '1, 1'b1, '0, '1);
		send_item(ACT_KEY, BTN_W'(5), 1'b0, MS_W'($urandom), MS_W'($urandom));
		for (int c = int'(ACT_PWR_OFF) + 1; c <= int'(ACT_CODE_MAX); c++)
			send_item(3'(c), BTN_W'($urandom), 1'($urandom), MS_W'($urandom), MS_W'($urandom));
		send_item(ACT_PWR_OFF, BTN_W'($urandom), 1'b1, '0, '0);
		// a fired key while off only marks the button
		send_item(ACT_DELAY, BTN_W'(9), 1'b1, '0, '1);
		send_item(ACT_ADVANCE, BTN_W'($urandom), 1'b0, '1, '0);
		send_item(ACT_ADVANCE, BTN_W'($urandom), 1'b0, '0, MS_W'(40));
	endtask

	task automatic test_power_cycle();
		send_item(ACT_PWR_ON, '0, 1'b0, '0, '0);
		send_item(ACT_PWR_ON, '1, 1'b1, '1, '1);
		send_item(ACT_KEY, '1, 1'b0, MS_W'($urandom), MS_W'($urandom));
		send_item(ACT_KEY, '0, 1'b1, MS_W'($urandom), MS_W'($urandom));
		send_item(ACT_DELAY, BTN_W'(17), 1'b1, '0, MS_W'($urandom));
		send_item(ACT_ADVANCE, BTN_W'($urandom), 1'b1, MS_W'($urandom), '0);
		send_item(ACT_ADVANCE, BTN_W'($urandom), 1'b1, MS_W'($urandom), MS_W'(32));
		send_item(ACT_PWR_OFF, '0, 1'b0, '0, '0);
		send_item(ACT_KEY, BTN_W'(3), 1'b1, MS_W'($urandom), MS_W'($urandom));
		send_item(ACT_PWR_ON, BTN_W'($urandom), 1'b0, '0, '0);
	endtask

	task automatic test_rate_settings();
		int rate_set[5] = '{1, 0, 262143, 192000, 1000};
		int ms_set[5] = '{65535, 123, 100, 0, 300};
		for (int k = 0; k < 5; k++) begin
			drain_block();
			write_rate(RATE_W'(rate_set[k]));
			send_item(ACT_DELAY, BTN_W'($urandom), 1'($urandom), MS_W'(ms_set[k]),
				MS_W'($urandom));
			send_item(ACT_ADVANCE, BTN_W'($urandom), 1'($urandom), MS_W'($urandom), '0);
			send_item(ACT_ADVANCE, BTN_W'($urandom), 1'($urandom), MS_W'($urandom), '1);
		end
	endtask

	task automatic test_queue_full();
		drain_block();
		if (!powered_model)
			send_item(ACT_PWR_ON, BTN_W'($urandom), 1'b0, '0, '0);
		while (pend_count > 0)
			send_item(ACT_ADVANCE, BTN_W'($urandom), 1'($urandom), MS_W'($urandom), '1);
		while (pend_count < QUEUE_DEPTH)
			send_item(ACT_DELAY, BTN_W'($urandom), 1'($urandom),
				MS_W'($urandom_range(10, 0)), MS_W'($urandom));
		// these two find the queue full
		repeat (2)
			send_item(ACT_DELAY, BTN_W'($urandom), 1'($urandom),
				MS_W'($urandom_range(10, 0)), MS_W'($urandom));
		send_item(ACT_ADVANCE, BTN_W'($urandom), 1'($urandom), MS_W'($urandom), '1);
		drain_block();
	endtask

	task automatic test_random_traffic(input int count, input logic [RATE_W-1:0] rate);
		drain_block();
		write_rate(rate);
		repeat (count) send_random_item();
	endtask

	// hold out_ready low in bursts of random length
	always @(posedge clk) begin
		if (sink_hold > 0) begin
			out_ready <= 1'b0;
			sink_hold <= sink_hold - 1;
		end else if (stall_pct > 0 && $urandom_range(99, 0) < stall_pct) begin
			out_ready <= 1'b0;
			sink_hold <= $urandom_range(4, 0);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_keys.size() == 0) begin
				report_mismatch("key event with none pending", 32'(key_index), '0);
			end else begin
				head_key = expected_keys.pop_front();
				if (key_index !== head_key.idx)
					report_mismatch("key_index", 32'(key_index), 32'(head_key.idx));
				if (key_pressed !== head_key.pressed)
					report_mismatch("key_pressed", 32'(key_pressed), 32'(head_key.pressed));
				if (last_in_run !== head_key.last)
					report_mismatch("last_in_run", 32'(last_in_run), 32'(head_key.last));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout with %0d key events outstanding", expected_keys.size());
			$display("delayed_key_event_scheduler_unit_tb failed");
			$finish;
		end
	end

	initial begin
		rate_model = RATE_RESET;
		frames_model = '0;
		powered_model = 1'b0;
		held_model = '0;
		pend_count = 0;
		run_len = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		gap_pct = 25;
		stall_pct = 20;
		test_unpowered_keys();
		test_power_cycle();
		test_rate_settings();
		test_queue_full();
		test_random_traffic(10, RATE_W'($urandom_range(192000, 1)));
		gap_pct = 0;
		stall_pct = 0;
		test_random_traffic(8, RATE_W'(48000));
		gap_pct = 20;
		stall_pct = 20;
		test_random_traffic(8, RATE_W'($urandom_range(192000, 1)));
		// no idling from here on
		gap_pct = 0;
		stall_pct = 0;
		test_random_traffic(8, RATE_RESET);
		drain_block();
		if (errors == 0)
			$display("delayed_key_event_scheduler_unit_tb passed");
		else
			$display("delayed_key_event_scheduler_unit_tb failed");
		$finish;
	end

endmodule
